FILE: hw/rtl/mlpq_pkg.sv
`default_nettype none

package mlpq_pkg;

  localparam int CAPACITY     = 64;
  localparam int NUM_LEVELS   = 8;
  localparam int PAYLOAD_BITS = 32;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LVL_W  = 3;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int DATA_W = 32;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_LIFT   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_BADLEVEL = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  typedef struct packed {
    logic  ins_en;
    lvl_t  ins_lvl;
    slot_t ins_slot;
    logic  dec_en;
    lvl_t  dec_lvl;
    logic  lift_en;
    slot_t lift_tail;
    cnt_t  lift_total;
  } lvl_cmd_t;

  typedef struct packed {
    logic  hit;
    slot_t tail;
  } lvl_query_t;

  typedef struct packed {
    logic  alloc_rd;
    logic  alloc_commit;
    logic  push_en;
    slot_t push_slot;
  } fs_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/multilevel_priority_queue_top.sv
// Insert steps through DECODE, INS1, INS2 and INS3; pop through DECODE, POP1 and POP2; lift
// through DECODE and LIFT, one linked-list step per cycle on the next-pointer RAM, then LIFT_END.
// Rejected or empty-queue operations go from DECODE to RESP. One operation is in flight at a time;
// the next input word is taken the cycle after the result is loaded into the output register.
// Synchronous active-low reset empties the queue and marks every slot free; no clearing pass.
`default_nettype none

module multilevel_priority_queue_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mlpq_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [mlpq_pkg::LVL_W-1:0]    in_level,
  input  wire logic [mlpq_pkg::DATA_W-1:0]   in_payload,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mlpq_pkg::ST_W-1:0]          out_status,
  output logic [mlpq_pkg::DATA_W-1:0]        out_popped_payload,
  output logic [mlpq_pkg::LVL_W-1:0]         out_popped_level
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_INS1     = 4'd2;
  localparam logic [3:0] S_INS2     = 4'd3;
  localparam logic [3:0] S_INS3     = 4'd4;
  localparam logic [3:0] S_POP1     = 4'd5;
  localparam logic [3:0] S_POP2     = 4'd6;
  localparam logic [3:0] S_LIFT     = 4'd7;
  localparam logic [3:0] S_LIFT_END = 4'd8;
  localparam logic [3:0] S_RESP     = 4'd9;

  logic [3:0]                           state_r, state_nxt;
  logic [mlpq_pkg::OP_W-1:0]            op_r;
  mlpq_pkg::lvl_t                       lvl_r;
  logic [mlpq_pkg::PAYLOAD_BITS-1:0]    pay_r;
  logic [mlpq_pkg::ST_W-1:0]            status_r, status_nxt;
  logic                                 hit_r, hit_nxt;
  mlpq_pkg::slot_t                      tail_r, tail_nxt;
  mlpq_pkg::slot_t                      slot_r, slot_nxt;
  mlpq_pkg::slot_t                      head_r, head_nxt;
  mlpq_pkg::slot_t                      cur_r, cur_nxt;
  logic                                 first_r, first_nxt;
  mlpq_pkg::cnt_t                       k_r, k_nxt;
  mlpq_pkg::cnt_t                       total_r, total_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [mlpq_pkg::ST_W-1:0]            out_status_r, out_status_nxt;
  logic [mlpq_pkg::DATA_W-1:0]          out_payload_r, out_payload_nxt;
  mlpq_pkg::lvl_t                       out_level_r, out_level_nxt;

  logic                                 in_take;
  logic                                 out_free;
  logic                                 out_load;
  mlpq_pkg::slot_t                      cur;

  mlpq_pkg::fs_cmd_t                    fs_cmd;
  mlpq_pkg::slot_t                      alloc_slot;
  mlpq_pkg::cnt_t                       free_count;
  mlpq_pkg::lvl_cmd_t                   lt_cmd;
  mlpq_pkg::lvl_query_t                 lt_query;

  logic                                 pay_we, pay_re;
  mlpq_pkg::slot_t                      pay_waddr, pay_raddr;
  logic [mlpq_pkg::PAYLOAD_BITS-1:0]    pay_rd;
  logic                                 lvl_we, lvl_re;
  mlpq_pkg::slot_t                      lvl_waddr, lvl_raddr;
  mlpq_pkg::lvl_t                       lvl_wdata, lvl_rd;
  logic                                 nxt_we, nxt_re;
  mlpq_pkg::slot_t                      nxt_waddr, nxt_raddr, nxt_wdata, nxt_rd;

  mlpq_free_stack u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fs_cmd),
    .alloc_slot(alloc_slot),
    .free_count(free_count)
  );

  mlpq_level_table u_level_table (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (lt_cmd),
    .q_lvl(lvl_r),
    .query(lt_query)
  );

  mlpq_ram #(
    .WIDTH(mlpq_pkg::PAYLOAD_BITS),
    .DEPTH(mlpq_pkg::CAPACITY)
  ) u_payload_ram (
    .clk  (clk),
    .we   (pay_we),
    .waddr(pay_waddr),
    .wdata(pay_r),
    .re   (pay_re),
    .raddr(pay_raddr),
    .rdata(pay_rd)
  );

  mlpq_ram #(
    .WIDTH(mlpq_pkg::LVL_W),
    .DEPTH(mlpq_pkg::CAPACITY)
  ) u_level_ram (
    .clk  (clk),
    .we   (lvl_we),
    .waddr(lvl_waddr),
    .wdata(lvl_wdata),
    .re   (lvl_re),
    .raddr(lvl_raddr),
    .rdata(lvl_rd)
  );

  mlpq_ram #(
    .WIDTH(mlpq_pkg::SLOT_W),
    .DEPTH(mlpq_pkg::CAPACITY)
  ) u_next_ram (
    .clk  (clk),
    .we   (nxt_we),
    .waddr(nxt_waddr),
    .wdata(nxt_wdata),
    .re   (nxt_re),
    .raddr(nxt_raddr),
    .rdata(nxt_rd)
  );

  assign in_stall           = (state_r != S_IDLE);
  assign in_take            = in_valid && !in_stall;
  assign out_free           = !out_valid_r || !out_stall;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_popped_payload = out_payload_r;
  assign out_popped_level   = out_level_r;
  assign cur                = first_r ? head_r : nxt_rd;

  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    hit_nxt         = hit_r;
    tail_nxt        = tail_r;
    slot_nxt        = slot_r;
    head_nxt        = head_r;
    cur_nxt         = cur_r;
    first_nxt       = first_r;
    k_nxt           = k_r;
    total_nxt       = total_r;
    out_load        = 1'b0;
    out_status_nxt  = out_status_r;
    out_payload_nxt = out_payload_r;
    out_level_nxt   = out_level_r;

    fs_cmd    = '0;
    lt_cmd    = '0;
    pay_we    = 1'b0;
    pay_re    = 1'b0;
    pay_waddr = alloc_slot;
    pay_raddr = head_r;
    lvl_we    = 1'b0;
    lvl_re    = 1'b0;
    lvl_waddr = alloc_slot;
    lvl_wdata = lvl_r;
    lvl_raddr = head_r;
    nxt_we    = 1'b0;
    nxt_re    = 1'b0;
    nxt_waddr = alloc_slot;
    nxt_wdata = head_r;
    nxt_raddr = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = mlpq_pkg::ST_OK;
        unique case (op_r)
          mlpq_pkg::OP_INSERT: begin
            priority if ({1'b0, lvl_r} >= (mlpq_pkg::LVL_W + 1)'(mlpq_pkg::NUM_LEVELS)) begin
              status_nxt = mlpq_pkg::ST_BADLEVEL;
              state_nxt  = S_RESP;
            end else if (free_count == '0) begin
              status_nxt = mlpq_pkg::ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_INS1;
            end
          end
          mlpq_pkg::OP_POP: begin
            if (free_count == mlpq_pkg::cnt_t'(mlpq_pkg::CAPACITY)) begin
              status_nxt = mlpq_pkg::ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_POP1;
            end
          end
          mlpq_pkg::OP_LIFT: begin
            total_nxt = mlpq_pkg::cnt_t'(mlpq_pkg::CAPACITY - free_count);
            first_nxt = 1'b1;
            k_nxt     = '0;
            if (free_count == mlpq_pkg::cnt_t'(mlpq_pkg::CAPACITY)) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_LIFT;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_INS1: begin
        fs_cmd.alloc_rd = 1'b1;
        nxt_re          = 1'b1;
        nxt_raddr       = lt_query.tail;
        hit_nxt         = lt_query.hit;
        tail_nxt        = lt_query.tail;
        state_nxt       = S_INS2;
      end
      S_INS2: begin
        pay_we    = 1'b1;
        lvl_we    = 1'b1;
        nxt_we    = 1'b1;
        nxt_wdata = hit_r ? nxt_rd : head_r;
        slot_nxt  = alloc_slot;
        if (!hit_r) begin
          head_nxt = alloc_slot;
        end
        state_nxt = S_INS3;
      end
      S_INS3: begin
        if (out_free) begin
          nxt_we              = hit_r;
          nxt_waddr           = tail_r;
          nxt_wdata           = slot_r;
          lt_cmd.ins_en       = 1'b1;
          lt_cmd.ins_lvl      = lvl_r;
          lt_cmd.ins_slot     = slot_r;
          fs_cmd.alloc_commit = 1'b1;
          out_load            = 1'b1;
          out_status_nxt      = mlpq_pkg::ST_OK;
          out_payload_nxt     = '0;
          out_level_nxt       = '0;
          state_nxt           = S_IDLE;
        end
      end
      S_POP1: begin
        pay_re    = 1'b1;
        lvl_re    = 1'b1;
        nxt_re    = 1'b1;
        state_nxt = S_POP2;
      end
      S_POP2: begin
        if (out_free) begin
          head_nxt         = nxt_rd;
          lt_cmd.dec_en    = 1'b1;
          lt_cmd.dec_lvl   = lvl_rd;
          fs_cmd.push_en   = 1'b1;
          fs_cmd.push_slot = head_r;
          out_load         = 1'b1;
          out_status_nxt   = mlpq_pkg::ST_OK;
          out_payload_nxt  = mlpq_pkg::DATA_W'(pay_rd);
          out_level_nxt    = lvl_rd;
          state_nxt        = S_IDLE;
        end
      end
      S_LIFT: begin
        lvl_we    = 1'b1;
        lvl_waddr = cur;
        lvl_wdata = '0;
        nxt_re    = 1'b1;
        nxt_raddr = cur;
        cur_nxt   = cur;
        first_nxt = 1'b0;
        k_nxt     = mlpq_pkg::cnt_t'(k_r + 1'b1);
        if (mlpq_pkg::cnt_t'(k_r + 1'b1) == total_r) begin
          state_nxt = S_LIFT_END;
        end
      end
      S_LIFT_END: begin
        if (out_free) begin
          lt_cmd.lift_en    = 1'b1;
          lt_cmd.lift_tail  = cur_r;
          lt_cmd.lift_total = total_r;
          out_load          = 1'b1;
          out_status_nxt    = mlpq_pkg::ST_OK;
          out_payload_nxt   = '0;
          out_level_nxt     = '0;
          state_nxt         = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_nxt  = status_r;
          out_payload_nxt = '0;
          out_level_nxt   = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_opcode;
      lvl_r <= in_level;
      pay_r <= in_payload[mlpq_pkg::PAYLOAD_BITS-1:0];
    end
    status_r      <= status_nxt;
    hit_r         <= hit_nxt;
    tail_r        <= tail_nxt;
    slot_r        <= slot_nxt;
    cur_r         <= cur_nxt;
    first_r       <= first_nxt;
    k_r           <= k_nxt;
    total_r       <= total_nxt;
    out_status_r  <= out_status_nxt;
    out_payload_r <= out_payload_nxt;
    out_level_r   <= out_level_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mlpq_ram.sv
`default_nettype none

module mlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mlpq_free_stack.sv
`default_nettype none

module mlpq_free_stack (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mlpq_pkg::fs_cmd_t cmd,
  output mlpq_pkg::slot_t       alloc_slot,
  output mlpq_pkg::cnt_t        free_count
);

  mlpq_pkg::cnt_t                     fc_r, fc_nxt;
  logic [mlpq_pkg::CAPACITY-1:0]      valid_r, valid_nxt;
  logic                               sel_r;
  mlpq_pkg::slot_t                    idx_r;
  mlpq_pkg::slot_t                    top_idx;
  mlpq_pkg::slot_t                    push_idx;
  mlpq_pkg::slot_t                    rd_data;

  assign push_idx = fc_r[mlpq_pkg::SLOT_W-1:0];
  assign top_idx  = mlpq_pkg::slot_t'(push_idx - 1'b1);

  mlpq_ram #(
    .WIDTH(mlpq_pkg::SLOT_W),
    .DEPTH(mlpq_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.push_en),
    .waddr(push_idx),
    .wdata(cmd.push_slot),
    .re   (cmd.alloc_rd),
    .raddr(top_idx),
    .rdata(rd_data)
  );

  // A stack entry never written reads as its own index.
  assign alloc_slot = sel_r ? rd_data : idx_r;
  assign free_count = fc_r;

  always_comb begin
    fc_nxt    = fc_r;
    valid_nxt = valid_r;
    priority if (cmd.push_en) begin
      fc_nxt              = mlpq_pkg::cnt_t'(fc_r + 1'b1);
      valid_nxt[push_idx] = 1'b1;
    end else if (cmd.alloc_commit) begin
      fc_nxt = mlpq_pkg::cnt_t'(fc_r - 1'b1);
    end else begin
      fc_nxt = fc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r    <= mlpq_pkg::cnt_t'(mlpq_pkg::CAPACITY);
      valid_r <= '0;
    end else begin
      fc_r    <= fc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_rd) begin
      sel_r <= valid_r[top_idx];
      idx_r <= top_idx;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mlpq_level_table.sv
`default_nettype none

module mlpq_level_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mlpq_pkg::lvl_cmd_t cmd,
  input  wire mlpq_pkg::lvl_t     q_lvl,
  output mlpq_pkg::lvl_query_t    query
);

  mlpq_pkg::cnt_t  count_r [mlpq_pkg::NUM_LEVELS];
  mlpq_pkg::cnt_t  count_nxt [mlpq_pkg::NUM_LEVELS];
  mlpq_pkg::slot_t tail_r [mlpq_pkg::NUM_LEVELS];
  mlpq_pkg::slot_t tail_nxt [mlpq_pkg::NUM_LEVELS];

  // The insert point is the tail of the lowest-priority nonempty level at or above q_lvl.
  always_comb begin
    query.hit  = 1'b0;
    query.tail = '0;
    for (int i = 0; i < mlpq_pkg::NUM_LEVELS; i++) begin
      if ((mlpq_pkg::lvl_t'(i) <= q_lvl) && (count_r[i] != '0)) begin
        query.hit  = 1'b1;
        query.tail = tail_r[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    tail_nxt  = tail_r;
    priority if (cmd.lift_en) begin
      for (int i = 0; i < mlpq_pkg::NUM_LEVELS; i++) begin
        count_nxt[i] = '0;
        tail_nxt[i]  = '0;
      end
      count_nxt[0] = cmd.lift_total;
      tail_nxt[0]  = cmd.lift_tail;
    end else if (cmd.ins_en) begin
      count_nxt[cmd.ins_lvl] = mlpq_pkg::cnt_t'(count_r[cmd.ins_lvl] + 1'b1);
      tail_nxt[cmd.ins_lvl]  = cmd.ins_slot;
    end else if (cmd.dec_en && (count_r[cmd.dec_lvl] != '0)) begin
      count_nxt[cmd.dec_lvl] = mlpq_pkg::cnt_t'(count_r[cmd.dec_lvl] - 1'b1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mlpq_pkg::NUM_LEVELS; i++) begin
        count_r[i] <= '0;
        tail_r[i]  <= '0;
      end
    end else begin
      count_r <= count_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mlpq_checker.sv
`default_nettype none

module mlpq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mlpq_pkg::ST_W-1:0]     out_status,
  input wire logic [mlpq_pkg::DATA_W-1:0]   out_popped_payload,
  input wire logic [mlpq_pkg::LVL_W-1:0]    out_popped_level
);

  // Only one operation is in flight, so a taken input word closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input word taken while an operation is in flight");

  // A new result word only appears at the end of an operation.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared with no operation in flight");

  a_zero_on_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != mlpq_pkg::ST_OK)) |->
      ((out_popped_payload == '0) && (out_popped_level == '0)))
    else $error("popped fields nonzero on a failed operation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_popped_payload) &&
       $stable(out_popped_level)))
    else $error("stalled result word changed");

endmodule

bind multilevel_priority_queue_top mlpq_checker u_mlpq_checker (.*);

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mlpq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1750;
  localparam int DRAIN_CYCLES = CAPACITY + 16;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    lvl_t              level;
    logic [DATA_W-1:0] payload;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] popped_payload;
    lvl_t              popped_level;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = '0;
  lvl_t in_level = '0;
  logic [DATA_W-1:0] in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [DATA_W-1:0] out_popped_payload;
  lvl_t out_popped_level;

  request_t pending_requests[$];
  response_t expected_responses[$];
  request_t driven_request;
  int unsigned total_requests;
  int unsigned sent_count;
  int unsigned received_count;
  int unsigned error_count;
  int unsigned cycle_count;

  // Shadow copy of the queue: linked entry store, free stack and per-level bookkeeping.
  logic [DATA_W-1:0] entry_payload[CAPACITY];
  lvl_t entry_level[CAPACITY];
  slot_t entry_next[CAPACITY];
  slot_t free_slots[CAPACITY];
  int unsigned free_count;
  slot_t head_slot;
  slot_t level_tail[NUM_LEVELS];
  int unsigned level_count[NUM_LEVELS];

  int unsigned inserts_seen, full_seen, pops_seen, empty_pops_seen, lifts_seen, unused_seen;
  int unsigned peak_occupancy;

  multilevel_priority_queue_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_level           (in_level),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_popped_payload (out_popped_payload),
    .out_popped_level   (out_popped_level)
  );

  always #5 clk = ~clk;

  function automatic response_t apply_queue_request(request_t req);
    response_t rsp;
    slot_t slot;
    slot_t anchor;
    slot_t cursor;
    bit found;
    int unsigned total;
    rsp = '0;
    found = 1'b0;
    anchor = '0;
    case (req.opcode)
      OP_INSERT: begin
        inserts_seen++;
        if (int'(req.level) >= NUM_LEVELS) begin
          rsp.status = ST_BADLEVEL;
        end else if (free_count == 0) begin
          rsp.status = ST_FULL;
          full_seen++;
        end else begin
          free_count--;
          slot = free_slots[free_count];
          entry_payload[slot] = req.payload;
          entry_level[slot] = req.level;
          // The new entry goes behind the tail of its own level or of the
          // nearest nonempty level above it; failing both it becomes the head.
          for (int k = int'(req.level); k >= 0; k--) begin
            if (!found && level_count[k] != 0) begin
              found = 1'b1;
              anchor = level_tail[k];
            end
          end
          if (found) begin
            entry_next[slot] = entry_next[anchor];
            entry_next[anchor] = slot;
          end else begin
            entry_next[slot] = head_slot;
            head_slot = slot;
          end
          level_tail[req.level] = slot;
          level_count[req.level]++;
          if (CAPACITY - free_count > peak_occupancy) peak_occupancy = CAPACITY - free_count;
        end
      end
      OP_POP: begin
        pops_seen++;
        if (free_count == CAPACITY) begin
          rsp.status = ST_EMPTY;
          empty_pops_seen++;
        end else begin
          slot = head_slot;
          rsp.popped_payload = entry_payload[slot];
          rsp.popped_level = entry_level[slot];
          if (level_count[entry_level[slot]] != 0) level_count[entry_level[slot]]--;
          head_slot = entry_next[slot];
          free_slots[free_count] = slot;
          free_count++;
        end
      end
      OP_LIFT: begin
        lifts_seen++;
        total = CAPACITY - free_count;
        if (total != 0) begin
          cursor = head_slot;
          for (int k = 0; k < total; k++) begin
            entry_level[cursor] = '0;
            if (k + 1 < total) cursor = entry_next[cursor];
          end
          for (int k = 0; k < NUM_LEVELS; k++) begin
            level_count[k] = 0;
            level_tail[k] = '0;
          end
          level_tail[0] = cursor;
          level_count[0] = total;
        end
      end
      default: begin
        unused_seen++;
      end
    endcase
    return rsp;
  endfunction

  function automatic int unsigned run_phase(int unsigned done);
    return (done * 3) / total_requests;
  endfunction

  function automatic logic [DATA_W-1:0] pick_payload();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, lvl_t lvl, logic [DATA_W-1:0] data);
    request_t req;
    req.opcode = op;
    req.level = lvl;
    req.payload = data;
    pending_requests.push_back(req);
  endtask

  // Sender side.
  always @(posedge clk) begin : drive_words
    int unsigned idle_pct;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_responses.push_back(apply_queue_request(driven_request));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        case (run_phase(sent_count))
          0: idle_pct = 15;
          1: idle_pct = 61;
          default: idle_pct = 0;
        endcase
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          driven_request = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_opcode <= driven_request.opcode;
          in_level <= driven_request.level;
          in_payload <= driven_request.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side.
  always @(posedge clk) begin : check_words
    response_t wanted;
    int unsigned stall_pct;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        received_count++;
        if (expected_responses.size() == 0) begin
          $error("result word with no request waiting: status %0d payload %h level %0d",
                 out_status, out_popped_payload, out_popped_level);
          error_count++;
        end else begin
          wanted = expected_responses.pop_front();
          if (out_status !== wanted.status) begin
            $error("status: expected %0d, actual %0d", wanted.status, out_status);
            error_count++;
          end
          if (out_popped_payload !== wanted.popped_payload) begin
            $error("popped_payload: expected %h, actual %h",
                   wanted.popped_payload, out_popped_payload);
            error_count++;
          end
          if (out_popped_level !== wanted.popped_level) begin
            $error("popped_level: expected %0d, actual %0d",
                   wanted.popped_level, out_popped_level);
            error_count++;
          end
        end
      end
      case (run_phase(received_count))
        0: stall_pct = 61;
        1: stall_pct = 15;
        default: stall_pct = 0;
      endcase
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_responses.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned seg_len;
    int unsigned insert_pct;
    int unsigned roll;
    int unsigned lvl_lo;
    int unsigned lvl_hi;
    int unsigned target;
    bit first_segment;

    for (int i = 0; i < CAPACITY; i++) free_slots[i] = slot_t'(i);
    free_count = CAPACITY;
    head_slot = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      level_tail[i] = '0;
      level_count[i] = 0;
    end

    add_request(OP_POP, 3'd0, 32'h0);
    add_request(OP_LIFT, 3'd0, 32'h0);
    add_request(OP_UNUSED, 3'd5, 32'hDEAD_BEEF);
    add_request(OP_INSERT, 3'd7, 32'h0000_0000);
    add_request(OP_INSERT, 3'd0, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 3'd3, 32'hA5A5_A5A5);
    add_request(OP_INSERT, 3'd3, 32'h5A5A_5A5A);
    add_request(OP_INSERT, 3'd1, 32'h0000_0001);
    add_request(OP_INSERT, 3'd7, 32'h8000_0000);
    add_request(OP_INSERT, 3'd0, 32'h7FFF_FFFF);
    add_request(OP_POP, 3'd6, 32'h1234_0000);
    add_request(OP_LIFT, 3'd4, 32'h0);
    add_request(OP_INSERT, 3'd2, 32'h1234_5678);
    add_request(OP_INSERT, 3'd0, 32'h8765_4321);
    for (int i = 0; i < 9; i++) add_request(OP_POP, 3'd0, 32'h0);
    add_request(OP_LIFT, 3'd0, 32'h0);

    // Random part: segments that lean toward filling, draining or a mix,
    // each with its own band of levels. The first one is the most insert-heavy and spans every level.
    target = pending_requests.size() + RANDOM_WORDS;
    first_segment = 1'b1;
    while (pending_requests.size() < target) begin
      if (first_segment) begin
        seg_len = 90;
        insert_pct = 92;
      end else begin
        seg_len = $urandom_range(90, 20);
        case ($urandom_range(3))
          0: insert_pct = 90;
          1: insert_pct = 15;
          default: insert_pct = 55;
        endcase
      end
      if (first_segment || $urandom_range(1)) begin
        lvl_lo = 0;
        lvl_hi = NUM_LEVELS - 1;
      end else begin
        lvl_lo = $urandom_range(NUM_LEVELS - 1);
        lvl_hi = $urandom_range(NUM_LEVELS - 1, lvl_lo);
      end
      first_segment = 1'b0;
      for (int i = 0; i < seg_len; i++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          add_request(OP_LIFT, lvl_t'($urandom), $urandom);
        end else if (roll < 5) begin
          add_request(OP_UNUSED, lvl_t'($urandom), $urandom);
        end else if ($urandom_range(99) < insert_pct) begin
          add_request(OP_INSERT, lvl_t'($urandom_range(lvl_hi, lvl_lo)), pick_payload());
        end else begin
          add_request(OP_POP, lvl_t'($urandom), $urandom);
        end
      end
    end
    total_requests = pending_requests.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count != total_requests || expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d inserts (%0d refused as full), %0d pops (%0d on empty),",
             total_requests, inserts_seen, full_seen, pops_seen, empty_pops_seen);
    $display("%0d lifts and %0d unused opcodes; peak occupancy %0d of %0d, %0d mismatches.",
             lifts_seen, unused_seen, peak_occupancy, CAPACITY, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_ram.sv
hw/rtl/mlpq_free_stack.sv
hw/rtl/mlpq_level_table.sv
hw/rtl/multilevel_priority_queue_top.sv
hw/rtl/mlpq_checker.sv
bench/testbench.sv
